// File: rtl/nst_pkg.sv
// Shared types and token codes for the spoken-number token generator.
package nst_pkg;

    localparam int MAX_TOKENS = 7;

    typedef logic [3:0] token_t;

    localparam token_t TOK_ZERO     = 4'd0;
    localparam token_t TOK_ONE      = 4'd1;
    localparam token_t TOK_TEN      = 4'd10;
    localparam token_t TOK_HUNDRED  = 4'd11;
    localparam token_t TOK_THOUSAND = 4'd12;

    localparam logic [13:0] MAX_NUMBER = 14'd9999;

    typedef struct packed {
        logic [3:0] d3;
        logic [3:0] d2;
        logic [3:0] d1;
        logic [3:0] d0;
    } digits_t;

    typedef struct packed {
        logic [MAX_TOKENS-1:0][3:0] tok;
        logic [2:0]                 cnt;
    } token_list_t;

endpackage

// File: rtl/nst_number_if.sv
// Request channel carrying the binary number to be read.
interface nst_number_if;
    logic        valid;
    logic        ready;
    logic [13:0] number_value;

    modport source (output valid, output number_value, input ready);
    modport sink   (input valid, input number_value, output ready);
endinterface

// File: rtl/nst_token_if.sv
// Request channel carrying one voice token and its end-of-reading flag.
interface nst_token_if;
    logic       valid;
    logic       ready;
    logic [3:0] token;
    logic       last;

    modport source (output valid, output token, output last, input ready);
    modport sink   (input valid, input token, input last, output ready);
endinterface

// File: rtl/number_to_spoken_tokens_top.sv
// Top level of the spoken-number token generator.
// Takes a binary number 0..9999 and sends the Chinese reading as voice tokens
// (0-9 digits, 10 ten, 11 hundred, 12 thousand), one per cycle while the
// receiver is ready, with last set on the final token; numbers above 9999 are
// dropped with no output. Digit extraction and token-list building run in a
// four-stage pipeline, after which a serializer sends the list. A number
// gives one to seven tokens; the serializer's one-token-per-cycle output sets
// the throughput, and the pipeline stalls while a list is still being sent.
module number_to_spoken_tokens_top
    import nst_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    nst_number_if.sink   number,
    nst_token_if.source  speech
);

    logic        en;
    logic        digits_valid;
    digits_t     digits;
    logic        list_valid;
    token_list_t list;
    logic        load;

    // whole pipeline advances when the list stage is empty or being drained
    assign en           = !list_valid || load;
    assign number.ready = en;

    nst_digits u_digits (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (number.valid),
        .in_number    (number.number_value),
        .digits_valid (digits_valid),
        .digits       (digits)
    );

    nst_tokens u_tokens (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .digits_valid (digits_valid),
        .digits       (digits),
        .list_valid   (list_valid),
        .list         (list)
    );

    nst_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .list_valid (list_valid),
        .list       (list),
        .load       (load),
        .out        (speech)
    );

endmodule

// File: rtl/nst_digits.sv
// Three-stage binary to decimal digit split with range check.
module nst_digits
    import nst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [13:0] in_number,
    output logic        digits_valid,
    output digits_t     digits
);

    // stage 1: n / 100 by reciprocal multiply, exact for n <= 9999
    logic [26:0] q_prod;
    logic        s1_valid_reg;
    logic [13:0] s1_n_reg;
    logic [6:0]  s1_q_reg;

    assign q_prod = {13'd0, in_number} * 27'd5243;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid && (in_number <= MAX_NUMBER);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_n_reg <= in_number;
            s1_q_reg <= q_prod[25:19];
        end
    end

    // stage 2: remainder mod 100, split quotient into thousands and hundreds
    logic [13:0] q_times_100;
    logic [13:0] rem_wide;
    logic [14:0] d3_prod;
    logic [3:0]  d3_val;
    logic [6:0]  d3_times_10;
    logic [6:0]  d2_wide;
    logic        s2_valid_reg;
    logic [6:0]  s2_r_reg;
    logic [3:0]  s2_d3_reg;
    logic [3:0]  s2_d2_reg;

    assign q_times_100 = {7'd0, s1_q_reg} * 14'd100;
    assign rem_wide    = s1_n_reg - q_times_100;
    assign d3_prod     = {8'd0, s1_q_reg} * 15'd205;
    assign d3_val      = d3_prod[14:11];
    assign d3_times_10 = {3'd0, d3_val} * 7'd10;
    assign d2_wide     = s1_q_reg - d3_times_10;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_r_reg  <= rem_wide[6:0];
            s2_d3_reg <= d3_val;
            s2_d2_reg <= d2_wide[3:0];
        end
    end

    // stage 3: split remainder into tens and units
    logic [14:0] d1_prod;
    logic [3:0]  d1_val;
    logic [6:0]  d1_times_10;
    logic [6:0]  d0_wide;
    logic        s3_valid_reg;
    digits_t     s3_digits_reg;

    assign d1_prod     = {8'd0, s2_r_reg} * 15'd205;
    assign d1_val      = d1_prod[14:11];
    assign d1_times_10 = {3'd0, d1_val} * 7'd10;
    assign d0_wide     = s2_r_reg - d1_times_10;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_digits_reg.d3 <= s2_d3_reg;
            s3_digits_reg.d2 <= s2_d2_reg;
            s3_digits_reg.d1 <= d1_val;
            s3_digits_reg.d0 <= d0_wide[3:0];
        end
    end

    assign digits_valid = s3_valid_reg;
    assign digits       = s3_digits_reg;

endmodule

// File: rtl/nst_tokens.sv
// Builds the token list of one reading from its four decimal digits.
module nst_tokens
    import nst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        digits_valid,
    input  digits_t     digits,
    output logic        list_valid,
    output token_list_t list
);

    token_list_t list_next;
    token_list_t list_reg;
    logic        list_valid_reg;
    logic [2:0]  c;

    always_comb
    begin
        list_next = '0;
        c         = 3'd0;
        if (digits.d3 == 4'd0 && digits.d2 == 4'd0 && digits.d1 == 4'd0)
        begin
            list_next.tok[c] = digits.d0;
            c = c + 3'd1;
        end
        else if (digits.d3 == 4'd0 && digits.d2 == 4'd0)
        begin
            // two digits: a leading one before ten is dropped
            if (digits.d1 != TOK_ONE)
            begin
                list_next.tok[c] = digits.d1;
                c = c + 3'd1;
            end
            list_next.tok[c] = TOK_TEN;
            c = c + 3'd1;
            if (digits.d0 != 4'd0)
            begin
                list_next.tok[c] = digits.d0;
                c = c + 3'd1;
            end
        end
        else
        begin
            if (digits.d3 != 4'd0)
            begin
                list_next.tok[c] = digits.d3;
                c = c + 3'd1;
                list_next.tok[c] = TOK_THOUSAND;
                c = c + 3'd1;
            end
            if (digits.d2 != 4'd0)
            begin
                list_next.tok[c] = digits.d2;
                c = c + 3'd1;
                list_next.tok[c] = TOK_HUNDRED;
                c = c + 3'd1;
            end
            else if (digits.d1 != 4'd0 || digits.d0 != 4'd0)
            begin
                // inner zero run collapses to one zero
                list_next.tok[c] = TOK_ZERO;
                c = c + 3'd1;
            end
            if (digits.d1 != 4'd0)
            begin
                list_next.tok[c] = digits.d1;
                c = c + 3'd1;
                list_next.tok[c] = TOK_TEN;
                c = c + 3'd1;
            end
            else if (digits.d2 != 4'd0 && digits.d0 != 4'd0)
            begin
                list_next.tok[c] = TOK_ZERO;
                c = c + 3'd1;
            end
            if (digits.d0 != 4'd0)
            begin
                list_next.tok[c] = digits.d0;
                c = c + 3'd1;
            end
        end
        list_next.cnt = c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            list_valid_reg <= digits_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            list_reg <= list_next;
        end
    end

    assign list_valid = list_valid_reg;
    assign list       = list_reg;

endmodule

// File: rtl/nst_serializer.sv
// Holds one token list and sends its tokens one per cycle while the receiver is ready.
module nst_serializer
    import nst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        list_valid,
    input  token_list_t list,
    output logic        load,
    nst_token_if.source out
);

    token_list_t hold_reg;
    logic        busy_reg;
    logic [2:0]  idx_reg;
    logic        at_last;

    assign at_last = (idx_reg == hold_reg.cnt - 3'd1);
    assign load    = !busy_reg || (out.ready && at_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else if (load)
        begin
            busy_reg <= list_valid;
            idx_reg  <= 3'd0;
        end
        else if (out.ready)
        begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            hold_reg <= list;
        end
    end

    assign out.valid = busy_reg;
    assign out.token = hold_reg.tok[idx_reg];
    assign out.last  = at_last;

endmodule

// File: bench/tb_number_to_spoken_tokens_top.sv
// Testbench for number_to_spoken_tokens_top: random and directed numbers, self-checked token stream.
module tb_number_to_spoken_tokens_top
    import nst_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_WAIT    = 11;
    localparam int TAIL_CYCLES = 20;
    localparam int HOLD_CYCLES = 200;

    typedef struct packed {
        token_t token;
        logic   last;
    } spoken_t;

    logic clk;
    logic rst_n;

    nst_number_if number_ch ();
    nst_token_if  speech_ch ();

    spoken_t spoken_q[$];

    int  fail_count;
    int  numbers_taken;
    int  numbers_dropped;
    int  tokens_seen;
    int  cycles;
    int  hold_ticks;
    int  sink_stall;
    bit  idle_src;
    bit  idle_sink;

    number_to_spoken_tokens_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_ch),
        .speech (speech_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        number_ch.valid        = 1'b0;
        number_ch.number_value = '0;
        speech_ch.ready        = 1'b0;
        fail_count             = 0;
        numbers_taken          = 0;
        numbers_dropped        = 0;
        tokens_seen            = 0;
        cycles                 = 0;
        hold_ticks             = 0;
        sink_stall             = 0;
        idle_src               = 1'b0;
        idle_sink              = 1'b0;
    end

    // Expected token sequence of one reading, appended to spoken_q.
    function automatic void expect_reading(logic [13:0] n);
        token_t      seq[$];
        int unsigned v;
        int unsigned th;
        int unsigned hu;
        int unsigned te;
        int unsigned un;
        v = n;
        if (v > MAX_NUMBER)
            return;
        un = v % 10;
        te = (v / 10) % 10;
        hu = (v / 100) % 10;
        th = v / 1000;
        if (v < 10)
            seq.push_back(token_t'(un));
        else if (v < 100)
        begin
            // a leading one before ten is silent
            if (te != 1)
                seq.push_back(token_t'(te));
            seq.push_back(TOK_TEN);
            if (un != 0)
                seq.push_back(token_t'(un));
        end
        else
        begin
            if (th != 0)
            begin
                seq.push_back(token_t'(th));
                seq.push_back(TOK_THOUSAND);
            end
            if (hu != 0)
            begin
                seq.push_back(token_t'(hu));
                seq.push_back(TOK_HUNDRED);
                if (te == 0)
                begin
                    if (un != 0)
                    begin
                        seq.push_back(TOK_ZERO);
                        seq.push_back(token_t'(un));
                    end
                end
                else
                begin
                    seq.push_back(token_t'(te));
                    seq.push_back(TOK_TEN);
                    if (un != 0)
                        seq.push_back(token_t'(un));
                end
            end
            else if (te != 0)
            begin
                seq.push_back(TOK_ZERO);
                seq.push_back(token_t'(te));
                seq.push_back(TOK_TEN);
                if (un != 0)
                    seq.push_back(token_t'(un));
            end
            else if (un != 0)
            begin
                seq.push_back(TOK_ZERO);
                seq.push_back(token_t'(un));
            end
        end
        foreach (seq[i])
            spoken_q.push_back(spoken_t'{token: seq[i], last: (i == seq.size() - 1)});
    endfunction

    // Mostly multi-digit numbers with frequent inner/trailing zeros, some out of range.
    function automatic logic [13:0] rand_number();
        int unsigned pick;
        int unsigned val;
        int unsigned ndig;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 14'($urandom_range(MAX_NUMBER + 1, 16383));
        if (pick < 3)
            return 14'($urandom_range(0, 9));
        if (pick < 6)
            return 14'($urandom_range(10, 99));
        ndig = (pick < 11) ? 3 : 4;
        val  = $urandom_range(1, 9);
        for (int k = 1; k < ndig; k++)
            val = val * 10 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9));
        return 14'(val);
    endfunction

    // Offer one number after a random gap; returns at the edge it is taken.
    task automatic send_number(input logic [13:0] value);
        int gap;
        gap = idle_src ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            number_ch.valid        <= 1'b0;
            number_ch.number_value <= 14'($urandom);
            repeat (gap) @(posedge clk);
        end
        number_ch.valid        <= 1'b1;
        number_ch.number_value <= value;
        do
            @(posedge clk);
        while (!number_ch.ready);
    endtask

    // Sender pauses until every expected token has come out.
    task automatic wait_for_readings();
        number_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (spoken_q.size() != 0);
        @(posedge clk);
    endtask

    task automatic test_special_readings();
        logic [13:0] picks[$] = '{14'd0, 14'd1, 14'd9, 14'd10, 14'd11, 14'd19, 14'd20,
                                  14'd99, 14'd100, 14'd101, 14'd110, 14'd111, 14'd1000,
                                  14'd1001, 14'd1010, 14'd1100, 14'd2005, 14'd3050,
                                  14'd9990, 14'd1234, 14'd9999, 14'd10000, 14'd16383};
        foreach (picks[i])
            send_number(picks[i]);
        wait_for_readings();
    endtask

    task automatic test_random_numbers(input int count);
        repeat (count)
            send_number(rand_number());
        wait_for_readings();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls.
    task automatic test_output_hold_off();
        @(negedge clk);
        hold_ticks = HOLD_CYCLES;
        @(posedge clk);
        idle_src = 1'b1;
        repeat (20)
            send_number(rand_number());
        idle_src = 1'b0;
        wait_for_readings();
    endtask

    task automatic test_back_to_back();
        idle_src  = 1'b1;
        idle_sink = 1'b1;
        repeat (20)
            send_number(rand_number());
        wait_for_readings();
        idle_src  = 1'b0;
        idle_sink = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_readings();
        test_random_numbers(80);
        test_output_hold_off();
        test_back_to_back();
        test_random_numbers(80);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Took %0d numbers (%0d above range, dropped), checked %0d tokens.",
                 numbers_taken, numbers_dropped, tokens_seen);
        $display("Ran zero patterns, all lengths, long output hold-off and full-rate traffic.");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Output pacing: per-token stall draw, plus a long hold-off when requested.
    always @(posedge clk)
    begin : sink_pace
        if (rst_n && speech_ch.valid && speech_ch.ready)
            sink_stall = idle_sink ? 0 : $urandom_range(0, MAX_WAIT);
        if (hold_ticks > 0)
        begin
            hold_ticks--;
            speech_ch.ready <= 1'b0;
        end
        else if (sink_stall > 0)
        begin
            sink_stall--;
            speech_ch.ready <= 1'b0;
        end
        else
            speech_ch.ready <= rst_n;
    end

    always @(posedge clk)
    begin : reading_check
        spoken_t want;
        if (rst_n && number_ch.valid && number_ch.ready)
        begin
            numbers_taken++;
            if (number_ch.number_value > MAX_NUMBER)
                numbers_dropped++;
            expect_reading(number_ch.number_value);
        end
        if (rst_n && speech_ch.valid && speech_ch.ready)
        begin
            tokens_seen++;
            if (spoken_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: unexpected token %0d last %0b",
                             speech_ch.token, speech_ch.last);
            end
            else
            begin
                want = spoken_q.pop_front();
                if (speech_ch.token !== want.token || speech_ch.last !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: token %0d last %0b, expected token %0d last %0b",
                                 speech_ch.token, speech_ch.last, want.token, want.last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d tokens still expected",
                     cycles, spoken_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
